// ===== rtl/urlb_pkg.sv =====
// Package for the UART receive ring line buffer.
// Holds the request, result, command and status types and the fixed codes.
// No dependencies; imported by the top level, the controller and the datapath.
`default_nettype none

package urlb_pkg;

  // Request codes carried in req_type.
  localparam logic [2:0] REQ_RX_BYTE  = 3'd0;
  localparam logic [2:0] REQ_SYNC     = 3'd1;
  localparam logic [2:0] REQ_GET_CHAR = 3'd2;
  localparam logic [2:0] REQ_GET_LINE = 3'd3;
  localparam logic [2:0] REQ_FLUSH    = 3'd4;

  // Result status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_OVF   = 2'd2;

  // Line terminator characters.
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  // Configuration register map.
  localparam int unsigned APB_AW             = 3;
  localparam logic        REG_IDX_LINE_LIMIT = 1'b0;
  localparam logic [6:0]  LINE_LIMIT_RESET   = 7'd64;
  localparam logic [6:0]  LINE_LIMIT_MAX     = 7'd64;

  // One input transaction.
  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] rx_byte;
  } req_t;

  // One result transaction.
  typedef struct packed {
    logic [1:0] status;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic [7:0] line_length;
    logic       last;
  } result_t;

  // Controller states.
  typedef enum logic [1:0] {
    CS_IDLE,
    CS_GET_CHAR,
    CS_SCAN,
    CS_EMIT
  } ctl_state_e;

  // Source of the store read address.
  typedef enum logic [1:0] {
    RA_NEXT_READ,
    RA_LINE_START,
    RA_NEXT_POS
  } raddr_sel_e;

  // Kind of result loaded into the output register.
  typedef enum logic [2:0] {
    RS_FLUSH,
    RS_OVF,
    RS_EMPTY,
    RS_CHAR,
    RS_LINE_NONE,
    RS_LINE_BYTE
  } res_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       rx_write;
    logic       do_sync;
    logic       do_flush;
    raddr_sel_e raddr_sel;
    logic       scan_init;
    logic       scan_step;
    logic       emit_init;
    logic       emit_step;
    logic       char_commit;
    logic       res_load;
    res_sel_e   res_sel;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic rx_enabled;
    logic overflow;
    logic pending_zero;
    logic match_hit;
    logic scan_last;
    logic emit_zero;
    logic emit_last;
  } dp_sts_t;

endpackage

`default_nettype wire

// ===== rtl/uart_rx_ring_line_buffer_unit.sv =====
// Top level of the UART receive ring line buffer: APB line_limit register,
// controller and datapath. Depends on urlb_pkg, urlb_ctrl and urlb_dp.
`default_nettype none

// Usage
// A request transaction is taken when start is high and busy is low. Receive
// byte, sync and flush complete in the accepting cycle and leave busy low, so
// such requests can follow back to back. Receive and sync give no result;
// flush gives one result in the next cycle.
// Get char gives one result: status results appear in the cycle after accept,
// a popped byte passes through the store read and then the result register.
// Get line scans the pending bytes one per cycle through the store read
// port, up to and including the LF.
// The line is then read again from its start and emitted one byte per cycle
// (at most line_limit-1 results), the last one marked by last.
// Busy stays high until the request completes; results are shown on result_o for
// exactly one cycle with result_valid_o and cannot be held off.
// Reset empties the buffer, enables reception and sets line_limit to 64;
// the byte store is not cleared and needs no clearing pass.
// line_limit is written through the APB port at byte address 0.
module uart_rx_ring_line_buffer_unit #(
  parameter int unsigned BUFFER_DEPTH = 256
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // Request channel.
  input  wire logic                            start,
  output logic                                 busy,
  input  wire urlb_pkg::req_t                  in_item_i,
  // Result channel.
  output logic                                 result_valid_o,
  output urlb_pkg::result_t                    result_o,
  // Configuration port.
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [urlb_pkg::APB_AW-1:0]     paddr,
  input  wire logic [31:0]                     pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);

  import urlb_pkg::*;

  logic [6:0] line_limit_q;
  logic       reg_sel;
  dp_cmd_t    cmd;
  dp_sts_t    sts;

  // Register decode.
  assign reg_sel = (paddr[APB_AW-1:2] == REG_IDX_LINE_LIMIT);

  // line_limit register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_limit_q <= LINE_LIMIT_RESET;
    end else if (psel && penable && pwrite && reg_sel) begin
      line_limit_q <= pwdata[6:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = reg_sel ? {25'd0, line_limit_q} : 32'd0;

  // Request sequencing.
  urlb_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .req_type_i(in_item_i.req_type),
    .sts_i     (sts),
    .cmd_o     (cmd),
    .busy_o    (busy)
  );

  // Storage, pointers and result formatting.
  urlb_dp #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx_byte_i   (in_item_i.rx_byte),
    .line_limit_i(line_limit_q),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .res_valid_o (result_valid_o),
    .res_o       (result_o)
  );

endmodule

`default_nettype wire

// ===== rtl/urlb_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Parameters set the word width and depth; no package dependency.
`default_nettype none

module urlb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== rtl/urlb_dp.sv =====
// Datapath of the receive ring line buffer: pointers, byte store, CR LF
// matcher, line counters and the result register. Uses urlb_pkg, urlb_ram.
`default_nettype none

module urlb_dp #(
  parameter int unsigned BUFFER_DEPTH = 256
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [7:0]        rx_byte_i,
  input  wire logic [6:0]        line_limit_i,
  input  wire urlb_pkg::dp_cmd_t cmd_i,
  output urlb_pkg::dp_sts_t      sts_o,
  output logic                   res_valid_o,
  output urlb_pkg::result_t      res_o
);

  import urlb_pkg::*;

  localparam int unsigned PW = $clog2(BUFFER_DEPTH);
  localparam int unsigned CW = (PW > 8) ? PW : 8;
  localparam logic [PW-1:0] LAST_POS = PW'(BUFFER_DEPTH - 1);

  function automatic logic [PW-1:0] wrap_next(input logic [PW-1:0] v);
    return (v == LAST_POS) ? '0 : v + PW'(1);
  endfunction

  // Architectural state.
  logic [PW-1:0] rd_ptr_q, wr_ptr_q, rx_pos_q;
  logic          ovf_q, rx_en_q;
  // Line scan and emit registers.
  logic [PW-1:0] start_q, pos_q, idx_q, count_q;
  logic          match_q;
  logic [5:0]    emit_left_q;
  logic [7:0]    shown_q;
  // Result register.
  logic          res_valid_q;
  result_t       res_q, res_d;

  logic [PW-1:0] next_rd, pending, raddr, line_len;
  logic [PW:0]   pending_wide;
  logic [7:0]    rdata;
  logic          byte_hit, sync_ovf;
  logic [6:0]    lim_eff;
  logic [5:0]    lim_m1, emit_cnt;
  logic [CW-1:0] len_ext;
  logic [7:0]    shown;

  // Byte store.
  urlb_ram #(
    .WIDTH(8),
    .DEPTH(BUFFER_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (cmd_i.rx_write),
    .waddr_i(rx_pos_q),
    .wdata_i(rx_byte_i),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // Pending count between the next read position and the write pointer.
  assign next_rd = wrap_next(rd_ptr_q);
  always_comb begin
    if (wr_ptr_q >= next_rd) begin
      pending_wide = {1'b0, wr_ptr_q} - {1'b0, next_rd};
    end else begin
      pending_wide = (PW+1)'(BUFFER_DEPTH) + {1'b0, wr_ptr_q} - {1'b0, next_rd};
    end
  end
  assign pending = pending_wide[PW-1:0];

  // Store read address selection.
  always_comb begin
    case (cmd_i.raddr_sel)
      RA_NEXT_READ:  raddr = next_rd;
      RA_LINE_START: raddr = start_q;
      RA_NEXT_POS:   raddr = wrap_next(pos_q);
      default:       raddr = next_rd;
    endcase
  end

  // Overflow check at sync: the read pointer lies strictly between the old
  // and the new write pointer, in either direction of travel.
  always_comb begin
    logic a_neg, b_neg, c_neg, all_nz;
    a_neg    = wr_ptr_q < rx_pos_q;
    b_neg    = rd_ptr_q < wr_ptr_q;
    c_neg    = rx_pos_q < rd_ptr_q;
    all_nz   = (wr_ptr_q != rx_pos_q) && (rd_ptr_q != wr_ptr_q) && (rx_pos_q != rd_ptr_q);
    sync_ovf = all_nz && (a_neg ^ b_neg ^ c_neg);
  end

  // CR LF matcher on the byte read for the current scan position.
  assign byte_hit = (rdata == (match_q ? CH_LF : CH_CR));

  // Line length, emitted byte count and saturated length.
  assign line_len = idx_q - PW'(1);
  assign len_ext  = CW'(line_len);
  always_comb begin
    if (line_limit_i == 7'd0) begin
      lim_eff = 7'd1;
    end else if (line_limit_i > LINE_LIMIT_MAX) begin
      lim_eff = LINE_LIMIT_MAX;
    end else begin
      lim_eff = line_limit_i;
    end
  end
  assign lim_m1   = 6'(lim_eff - 7'd1);
  assign emit_cnt = (len_ext < CW'(lim_m1)) ? len_ext[5:0] : lim_m1;
  assign shown    = (len_ext > CW'(255)) ? 8'hFF : len_ext[7:0];

  // Status toward the controller.
  always_comb begin
    sts_o.rx_enabled   = rx_en_q;
    sts_o.overflow     = ovf_q;
    sts_o.pending_zero = (pending == '0);
    sts_o.match_hit    = match_q && byte_hit;
    sts_o.scan_last    = (({1'b0, idx_q} + (PW+1)'(1)) == {1'b0, count_q});
    sts_o.emit_zero    = (emit_cnt == 6'd0);
    sts_o.emit_last    = (emit_left_q == 6'd1);
  end

  // Pointers and flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= LAST_POS;
      wr_ptr_q <= '0;
      rx_pos_q <= '0;
      ovf_q    <= 1'b0;
      rx_en_q  <= 1'b1;
    end else begin
      if (cmd_i.do_flush) begin
        rd_ptr_q <= LAST_POS;
        wr_ptr_q <= '0;
        rx_pos_q <= '0;
        ovf_q    <= 1'b0;
        rx_en_q  <= 1'b1;
      end
      if (cmd_i.rx_write) begin
        rx_pos_q <= wrap_next(rx_pos_q);
      end
      if (cmd_i.do_sync) begin
        wr_ptr_q <= rx_pos_q;
        if (sync_ovf) begin
          ovf_q   <= 1'b1;
          rx_en_q <= 1'b0;
        end
      end
      if (cmd_i.char_commit) begin
        rd_ptr_q <= next_rd;
      end
      if (cmd_i.emit_init) begin
        rd_ptr_q <= pos_q;
      end
    end
  end

  // Scan and emit working registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_init) begin
      start_q <= next_rd;
      pos_q   <= next_rd;
      idx_q   <= '0;
      count_q <= pending;
      match_q <= 1'b0;
    end
    if (cmd_i.scan_step) begin
      pos_q   <= wrap_next(pos_q);
      idx_q   <= idx_q + PW'(1);
      match_q <= !match_q && byte_hit;
    end
    if (cmd_i.emit_init) begin
      pos_q       <= start_q;
      emit_left_q <= emit_cnt;
      shown_q     <= shown;
    end
    if (cmd_i.emit_step) begin
      pos_q       <= wrap_next(pos_q);
      emit_left_q <= emit_left_q - 6'd1;
    end
  end

  // Result formatting.
  always_comb begin
    res_d = '0;
    res_d.last = 1'b1;
    case (cmd_i.res_sel)
      RS_FLUSH: res_d.status = ST_OK;
      RS_OVF:   res_d.status = ST_OVF;
      RS_EMPTY: res_d.status = ST_EMPTY;
      RS_CHAR: begin
        res_d.status     = ST_OK;
        res_d.data_byte  = rdata;
        res_d.byte_valid = 1'b1;
      end
      RS_LINE_NONE: begin
        res_d.status      = ST_OK;
        res_d.line_length = shown;
      end
      RS_LINE_BYTE: begin
        res_d.status      = ST_OK;
        res_d.data_byte   = rdata;
        res_d.byte_valid  = 1'b1;
        res_d.line_length = shown_q;
        res_d.last        = (emit_left_q == 6'd1);
      end
      default: res_d.status = ST_OK;
    endcase
  end

  // Result register: strobe for one cycle per loaded result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= cmd_i.res_load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

// ===== rtl/urlb_ctrl.sv =====
// Controller of the receive ring line buffer: request decode and the
// get-char, line scan and line emit sequencing. Uses urlb_pkg.
`default_nettype none

module urlb_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [2:0]        req_type_i,
  input  wire urlb_pkg::dp_sts_t sts_i,
  output urlb_pkg::dp_cmd_t      cmd_o,
  output logic                   busy_o
);

  import urlb_pkg::*;

  ctl_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      CS_IDLE: begin
        if (start_i && !sts_i.overflow && !sts_i.pending_zero) begin
          if (req_type_i == REQ_GET_CHAR) begin
            state_d = CS_GET_CHAR;
          end else if (req_type_i == REQ_GET_LINE) begin
            state_d = CS_SCAN;
          end
        end
      end
      CS_GET_CHAR: state_d = CS_IDLE;
      CS_SCAN: begin
        if (sts_i.match_hit) begin
          state_d = sts_i.emit_zero ? CS_IDLE : CS_EMIT;
        end else if (sts_i.scan_last) begin
          state_d = CS_IDLE;
        end
      end
      CS_EMIT: begin
        if (sts_i.emit_last) begin
          state_d = CS_IDLE;
        end
      end
      default: state_d = CS_IDLE;
    endcase
  end

  // Datapath commands.
  always_comb begin
    cmd_o           = '0;
    cmd_o.raddr_sel = RA_NEXT_READ;
    cmd_o.res_sel   = RS_FLUSH;
    case (state_q)
      CS_IDLE: begin
        if (start_i) begin
          case (req_type_i)
            REQ_RX_BYTE: cmd_o.rx_write = sts_i.rx_enabled;
            REQ_SYNC:    cmd_o.do_sync  = 1'b1;
            REQ_GET_CHAR, REQ_GET_LINE: begin
              if (sts_i.overflow) begin
                cmd_o.res_load = 1'b1;
                cmd_o.res_sel  = RS_OVF;
              end else if (sts_i.pending_zero) begin
                cmd_o.res_load = 1'b1;
                cmd_o.res_sel  = RS_EMPTY;
              end else begin
                cmd_o.scan_init = (req_type_i == REQ_GET_LINE);
              end
            end
            REQ_FLUSH: begin
              cmd_o.do_flush = 1'b1;
              cmd_o.res_load = 1'b1;
              cmd_o.res_sel  = RS_FLUSH;
            end
            default: cmd_o.rx_write = 1'b0;
          endcase
        end
      end
      CS_GET_CHAR: begin
        cmd_o.char_commit = 1'b1;
        cmd_o.res_load    = 1'b1;
        cmd_o.res_sel     = RS_CHAR;
      end
      CS_SCAN: begin
        if (sts_i.match_hit) begin
          cmd_o.raddr_sel = RA_LINE_START;
          cmd_o.emit_init = 1'b1;
          if (sts_i.emit_zero) begin
            cmd_o.res_load = 1'b1;
            cmd_o.res_sel  = RS_LINE_NONE;
          end
        end else if (sts_i.scan_last) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_sel  = RS_EMPTY;
        end else begin
          cmd_o.raddr_sel = RA_NEXT_POS;
          cmd_o.scan_step = 1'b1;
        end
      end
      CS_EMIT: begin
        cmd_o.raddr_sel = RA_NEXT_POS;
        cmd_o.emit_step = 1'b1;
        cmd_o.res_load  = 1'b1;
        cmd_o.res_sel   = RS_LINE_BYTE;
      end
      default: cmd_o.res_load = 1'b0;
    endcase
  end

  assign busy_o = (state_q != CS_IDLE);

endmodule

`default_nettype wire
